// ----- rtl/ssdc_pkg.sv -----
// Shared types and constants for the submatrix divisibility counter.
// No dependencies.
package ssdc_pkg;
    localparam int CountW = 23;
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam int ElemW = 32;

    typedef enum logic [1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1,
        CFG_DIV  = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LRD0, S_LRD1, S_LRD2, S_LWAIT, S_LWR,
        S_PAIR, S_CLR, S_CRD0, S_CRD1, S_CRD2, S_CRD3, S_CWAIT,
        S_DIV, S_TRD, S_TWAIT, S_TWR, S_NEXT, S_DONE
    } st_t;
endpackage

// ----- rtl/ssdc_ram.sv -----
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module ssdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/submatrix_sum_divisible_counter.sv -----
// Submatrix divisibility counter: a result-free load phase followed by a
// multi-cycle sweep. Depends on ssdc_pkg and ssdc_ram.
//
// Send the matrix one element per request in row-major order. After each
// request busy stays high while the upper, left and diagonal prefix sums are
// read and the new prefix sum is written. After the last element busy stays
// high for the sweep: for every pair of top and bottom rows, a reset of the
// remainder table, then for each column four prefix reads, a restoring
// remainder step, the table read-modify-write and the index advance, and one
// final cycle that shows the count on match_count with done high; it cannot be
// stalled. Write configuration only while busy is low; any write to the rows,
// columns or divisor register restarts the load.
module submatrix_sum_divisible_counter #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int MAX_DIVISOR = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [31:0]        element_value,
    output logic                      done,
    output logic [ssdc_pkg::CountW-1:0] match_count,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [12:0]               cfg_data
);
    import ssdc_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int KW  = $clog2(MAX_DIVISOR + 1);
    localparam int TW  = $clog2(MAX_DIVISOR);
    localparam int PD  = MAX_ROWS * MAX_COLS;
    localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
    localparam int SW  = 64;

    st_t st_reg, st_next;

    logic [6:0]  rows_cfg_reg, cols_cfg_reg;
    logic [12:0] div_cfg_reg;
    logic [RCW-1:0] rows;
    logic [CCW-1:0] cols;
    logic [KW-1:0]  kval;

    always_comb
    begin
        rows = (rows_cfg_reg == 7'd0) ? RCW'(1)
             : (32'(rows_cfg_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_cfg_reg);
        cols = (cols_cfg_reg == 7'd0) ? CCW'(1)
             : (32'(cols_cfg_reg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_cfg_reg);
        kval = (div_cfg_reg == 13'd0) ? KW'(1)
             : (32'(div_cfg_reg) > MAX_DIVISOR) ? KW'(MAX_DIVISOR) : KW'(div_cfg_reg);
    end

    // load position and sweep indices
    logic [RCW-1:0] lr_reg, top_reg, bot_reg;
    logic [CCW-1:0] lc_reg, col_reg;
    logic [TW:0]    clr_reg;
    logic signed [SW-1:0] acc_reg, val_reg;
    logic [TW-1:0]  rem_reg;
    logic [CountW-1:0] total_reg;
    logic [6:0]     dstep_reg;
    logic [SW-1:0]  dq_reg;
    logic [KW:0]    drem_reg;
    logic           dneg_reg;

    // prefix memory
    logic           p_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [SW-1:0]  p_wdata, p_rdata;

    ssdc_ram #(.WIDTH(SW), .DEPTH(PD)) u_prefix (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    // remainder table
    logic           t_we;
    logic [TW-1:0]  t_waddr, t_raddr;
    logic [CountW-1:0] t_wdata, t_rdata;

    ssdc_ram #(.WIDTH(CountW), .DEPTH(MAX_DIVISOR)) u_table (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    function automatic logic [PAW-1:0] paddr(input logic [RCW-1:0] r, input logic [CCW-1:0] c);
        logic [31:0] a;
        a = 32'(r) * MAX_COLS + 32'(c);
        return a[PAW-1:0];
    endfunction

    // read coordinates for the current read slot; a border coordinate reads as zero
    logic [RCW-1:0] rr;
    logic [CCW-1:0] rc;
    logic           rzero;
    logic           rzero_reg;

    always_comb
    begin
        rr = '0;
        rc = '0;
        rzero = 1'b0;
        unique case (st_reg)
            S_LRD0: begin rr = lr_reg - 1'b1; rc = lc_reg;        rzero = (lr_reg == 0); end
            S_LRD1: begin rr = lr_reg;        rc = lc_reg - 1'b1; rzero = (lc_reg == 0); end
            S_LRD2: begin rr = lr_reg - 1'b1; rc = lc_reg - 1'b1;
                          rzero = (lr_reg == 0) || (lc_reg == 0); end
            S_CRD0: begin rr = bot_reg;       rc = col_reg;       rzero = 1'b0; end
            S_CRD1: begin rr = top_reg - 1'b1; rc = col_reg;      rzero = (top_reg == 0); end
            S_CRD2: begin rr = bot_reg;       rc = col_reg - 1'b1; rzero = (col_reg == 0); end
            S_CRD3: begin rr = top_reg - 1'b1; rc = col_reg - 1'b1;
                          rzero = (top_reg == 0) || (col_reg == 0); end
            default: ;
        endcase
        p_raddr = paddr(rr, rc);
    end

    logic signed [SW-1:0] pval;
    assign pval = rzero_reg ? '0 : p_rdata;

    assign p_we    = (st_reg == S_LWR);
    assign p_waddr = paddr(lr_reg, lc_reg);
    assign p_wdata = acc_reg;

    logic [TW-1:0] clr_addr;
    assign clr_addr = clr_reg[TW-1:0];
    assign t_raddr  = rem_reg;
    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = rem_reg;
        t_wdata = t_rdata + 1'b1;
        if (st_reg == S_CLR)
        begin
            t_we    = 1'b1;
            t_waddr = clr_addr;
            t_wdata = (clr_reg == 0) ? CountW'(1) : '0;
        end
        else if (st_reg == S_TWR)
        begin
            t_we = 1'b1;
        end
    end

    logic [TW:0] clr_last;
    assign clr_last = (TW + 1)'(kval - 1'b1);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:  if (start) st_next = S_LRD0;
            S_LRD0:  st_next = S_LRD1;
            S_LRD1:  st_next = S_LRD2;
            S_LRD2:  st_next = S_LWAIT;
            S_LWAIT: st_next = S_LWR;
            S_LWR:   st_next = ((lr_reg == rows - 1'b1) && (lc_reg == CCW'(cols - 1'b1)))
                               ? S_PAIR : S_IDLE;
            S_PAIR:  st_next = S_CLR;
            S_CLR:   if (clr_reg == clr_last) st_next = S_CRD0;
            S_CRD0:  st_next = S_CRD1;
            S_CRD1:  st_next = S_CRD2;
            S_CRD2:  st_next = S_CRD3;
            S_CRD3:  st_next = S_CWAIT;
            S_CWAIT: st_next = S_DIV;
            S_DIV:   if (dstep_reg == 7'd64) st_next = S_TRD;
            S_TRD:   st_next = S_TWAIT;
            S_TWAIT: st_next = S_TWR;
            S_TWR:   st_next = S_NEXT;
            S_NEXT:
            begin
                if (col_reg != CCW'(cols - 1'b1))       st_next = S_CRD0;
                else if (bot_reg != rows - 1'b1)        st_next = S_PAIR;
                else if (top_reg != rows - 1'b1)        st_next = S_PAIR;
                else                                    st_next = S_DONE;
            end
            S_DONE:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign busy = (st_reg != S_IDLE);
    assign done = (st_reg == S_DONE);
    assign match_count = total_reg;

    // divider: |acc| mod k, restoring, one bit per cycle
    logic [KW:0] dtrial;
    assign dtrial = {drem_reg[KW-1:0], dq_reg[SW-1]};

    // new remainder after division: rem + (s mod k) wrapped into [0, k)
    logic [KW:0] smod, rsum;
    always_comb
    begin
        smod = (dneg_reg && drem_reg != 0) ? ((KW + 1)'(kval) - drem_reg) : drem_reg;
        rsum = (KW + 1)'(rem_reg) + smod;
        if (rsum >= (KW + 1)'(kval))
        begin
            rsum = rsum - (KW + 1)'(kval);
        end
    end

    logic [CountW:0] tsum;
    assign tsum = {1'b0, total_reg} + {1'b0, t_rdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 7'd64;
            cols_cfg_reg <= 7'd64;
            div_cfg_reg  <= 13'd1;
            lr_reg       <= '0;
            lc_reg       <= '0;
            top_reg      <= '0;
            bot_reg      <= '0;
            col_reg      <= '0;
            clr_reg      <= '0;
            rzero_reg    <= 1'b0;
            total_reg    <= '0;
            rem_reg      <= '0;
            dstep_reg    <= '0;
        end
        else
        begin
            rzero_reg <= rzero;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROWS: rows_cfg_reg <= cfg_data[6:0];
                    CFG_COLS: cols_cfg_reg <= cfg_data[6:0];
                    CFG_DIV:  div_cfg_reg  <= cfg_data;
                    default: ;
                endcase
                if (cfg_index <= CFG_DIV)
                begin
                    lr_reg <= '0;
                    lc_reg <= '0;
                end
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        val_reg <= SW'(element_value);
                        if ((lr_reg >= rows) || (lc_reg >= cols))
                        begin
                            lr_reg <= '0;
                            lc_reg <= '0;
                        end
                    end
                end
                S_LRD0:
                begin
                    acc_reg <= val_reg;
                end
                S_LRD1:
                begin
                    acc_reg <= acc_reg + pval;  // upper
                end
                S_LRD2:
                begin
                    acc_reg <= acc_reg + pval;  // left
                end
                S_LWAIT:
                begin
                    acc_reg <= acc_reg - pval;  // diagonal
                end
                S_LWR:
                begin
                    if (lc_reg == CCW'(cols - 1'b1))
                    begin
                        lc_reg <= '0;
                        lr_reg <= (lr_reg == rows - 1'b1) ? '0 : lr_reg + 1'b1;
                    end
                    else
                    begin
                        lc_reg <= lc_reg + 1'b1;
                    end
                    if ((lr_reg == rows - 1'b1) && (lc_reg == CCW'(cols - 1'b1)))
                    begin
                        top_reg   <= '0;
                        bot_reg   <= '0;
                        total_reg <= '0;
                    end
                end
                S_PAIR:
                begin
                    clr_reg <= '0;
                    col_reg <= '0;
                    rem_reg <= '0;
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                S_CRD1:
                begin
                    acc_reg <= pval;            // bottom,col
                end
                S_CRD2:
                begin
                    acc_reg <= acc_reg - pval;  // top-1,col
                end
                S_CRD3:
                begin
                    acc_reg <= acc_reg - pval;  // bottom,col-1
                end
                S_CWAIT:
                begin
                    dneg_reg  <= (acc_reg + pval) < 0;
                    dq_reg    <= ((acc_reg + pval) < 0) ? -(acc_reg + pval) : (acc_reg + pval);
                    drem_reg  <= '0;
                    dstep_reg <= '0;
                end
                S_DIV:
                begin
                    if (dstep_reg != 7'd64)
                    begin
                        dstep_reg <= dstep_reg + 1'b1;
                        dq_reg    <= {dq_reg[SW-2:0], 1'b0};
                        drem_reg  <= (dtrial >= (KW + 1)'(kval)) ? dtrial - (KW + 1)'(kval)
                                                                 : dtrial;
                    end
                    else
                    begin
                        rem_reg <= rsum[TW-1:0];
                    end
                end
                S_TWAIT:
                begin
                    total_reg <= tsum[CountW] ? CountMax : tsum[CountW-1:0];
                end
                S_NEXT:
                begin
                    if (col_reg != CCW'(cols - 1'b1))
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                    else if (bot_reg != rows - 1'b1)
                    begin
                        bot_reg <= bot_reg + 1'b1;
                    end
                    else
                    begin
                        top_reg <= top_reg + 1'b1;
                        bot_reg <= top_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
